FILE: src/lsp_pkg.sv
// Shared types, constants and helpers for the LED status pattern generator.
// Used by the front, queue, back and top-level modules. No dependencies.
`default_nettype none

package lsp_pkg;

	// ring size; led_index carries PIXEL_COUNT for the status LED
	localparam int PIXEL_COUNT = 8;
	localparam int IDX_W = $clog2(PIXEL_COUNT + 1);
	localparam int POS_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	// frame queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FLASH_HOLD   = 1'b1;
	localparam logic [9:0]  FRAME_PERIOD_RESET = 10'd33;
	localparam logic [15:0] FLASH_HOLD_RESET   = 16'd600;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	// display modes
	typedef enum logic [2:0] {
		MODE_IDLE       = 3'd0,
		MODE_SCANNING   = 3'd1,
		MODE_ATTACK     = 3'd2,
		MODE_CAPTURE_OK = 3'd3,
		MODE_ERROR      = 3'd4
	} mode_t;

	// pattern timing in ms
	localparam int SCAN_STEP_MS = 120;
	localparam int OK_BLINK_MS  = 80;
	localparam int ERR_BLINK_MS = 150;

	// breathing levels: base + tri * span / 128
	localparam int IDLE_BASE   = 10;
	localparam int IDLE_SPAN   = 70;
	localparam int ATTACK_BASE = 40;
	localparam int ATTACK_SPAN = 215;
	localparam int LEVEL_SHIFT = 7;

	// divide by three for values below 256: (x * 171) >> 9
	localparam int THIRD_MUL   = 171;
	localparam int THIRD_SHIFT = 9;

	// colour levels
	localparam logic [7:0] LVL_FULL     = 8'd255;
	localparam logic [7:0] LVL_SCAN_DIM = 8'd20;
	localparam logic [7:0] LVL_SCAN_DOT = 8'd180;
	localparam logic [7:0] LVL_OFF      = 8'd0;

	// input word
	typedef struct packed {
		logic       cmd;
		logic [2:0] mode;
	} in_item_t;

	// output word, one per LED
	typedef struct packed {
		logic [3:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} out_item_t;

	// configuration register values
	typedef struct packed {
		logic [9:0]  frame_period_ms;
		logic [15:0] flash_hold_ms;
	} cfg_t;

	// one frame as decided by the front
	typedef struct packed {
		mode_t            mode;
		logic [POS_W-1:0] pos;
		logic [7:0]       level;
		logic             on;
	} frame_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// triangle wave over one byte of phase
	function automatic logic [6:0] tri_wave(input logic [7:0] p);
		return p[7] ? ~p[6:0] : p[6:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/lsp_queue.sv
// Short frame queue between the front and the back of the pattern generator.
// Depends on lsp_pkg for the frame and status types.
`default_nettype none

module lsp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lsp_pkg::frame_t push_frame,
	input  wire logic            pop,
	output lsp_pkg::frame_t      head,
	output lsp_pkg::q_stat_t     stat
);

	localparam int PTR_W = (lsp_pkg::QUEUE_DEPTH > 1) ? $clog2(lsp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(lsp_pkg::QUEUE_DEPTH + 1);

	lsp_pkg::frame_t  entry_q [lsp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// status and head word
	assign stat.full  = (count_q == CNT_W'(lsp_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/lsp_front.sv
// Front of the pattern generator: takes ticks and mode sets, keeps time and
// mode state, and queues one frame word per frame due. Depends on lsp_pkg.
`default_nettype none

module lsp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire lsp_pkg::in_item_t  item,
	input  wire lsp_pkg::cfg_t      cfg,
	input  wire lsp_pkg::q_stat_t   q_stat,
	output logic                    push,
	output lsp_pkg::frame_t         push_frame
);

	// time and mode state
	logic [31:0]               time_q;
	logic [31:0]               last_frame_q;
	logic [31:0]               flash_start_q;
	lsp_pkg::mode_t            mode_q;
	lsp_pkg::mode_t            saved_q;

	// running remainders of the millisecond clock
	logic [6:0]                scan_rem_q;
	logic [lsp_pkg::POS_W-1:0] scan_pos_q;
	logic [6:0]                ok_rem_q;
	logic                      ok_phase_q;
	logic [7:0]                err_rem_q;
	logic                      err_phase_q;

	logic                      accept;
	logic                      tick;
	logic                      set_ok;
	logic                      set_flash;
	logic                      wrap;
	logic [31:0]               now;
	logic [6:0]                scan_rem_n;
	logic [lsp_pkg::POS_W-1:0] scan_pos_n;
	logic [6:0]                ok_rem_n;
	logic                      ok_phase_n;
	logic [7:0]                err_rem_n;
	logic                      err_phase_n;
	logic [31:0]               elapsed;
	logic [31:0]               flash_age;
	logic                      frame_due;
	logic                      expired;
	logic                      is_flash;
	lsp_pkg::mode_t            draw_mode;
	logic [6:0]                tri_idle;
	logic [6:0]                tri_atk;
	logic [13:0]               prod_idle;
	logic [14:0]               prod_atk;
	logic [7:0]                lvl_idle;
	logic [7:0]                lvl_atk;

	// handshake: hold off only while the queue has no room
	assign item_stall = q_stat.full;
	assign accept     = item_valid && !q_stat.full;
	assign tick       = accept && (item.cmd == lsp_pkg::CMD_TICK);
	assign set_ok     = accept && (item.cmd == lsp_pkg::CMD_SET)
		&& (item.mode <= 3'(lsp_pkg::MODE_ERROR));
	assign set_flash  = (item.mode == 3'(lsp_pkg::MODE_CAPTURE_OK))
		|| (item.mode == 3'(lsp_pkg::MODE_ERROR));

	// next millisecond and its remainders; all restart when the clock wraps
	assign wrap = &time_q;
	assign now  = time_q + 32'd1;

	always_comb begin
		scan_rem_n  = scan_rem_q + 7'd1;
		scan_pos_n  = scan_pos_q;
		ok_rem_n    = ok_rem_q + 7'd1;
		ok_phase_n  = ok_phase_q;
		err_rem_n   = err_rem_q + 8'd1;
		err_phase_n = err_phase_q;
		if (scan_rem_q == 7'(lsp_pkg::SCAN_STEP_MS - 1)) begin
			scan_rem_n = '0;
			if (scan_pos_q == lsp_pkg::POS_W'(lsp_pkg::PIXEL_COUNT - 1)) begin
				scan_pos_n = '0;
			end else begin
				scan_pos_n = scan_pos_q + lsp_pkg::POS_W'(1);
			end
		end
		if (ok_rem_q == 7'(lsp_pkg::OK_BLINK_MS - 1)) begin
			ok_rem_n   = '0;
			ok_phase_n = !ok_phase_q;
		end
		if (err_rem_q == 8'(lsp_pkg::ERR_BLINK_MS - 1)) begin
			err_rem_n   = '0;
			err_phase_n = !err_phase_q;
		end
		if (wrap) begin
			scan_rem_n  = '0;
			scan_pos_n  = '0;
			ok_rem_n    = '0;
			ok_phase_n  = 1'b0;
			err_rem_n   = '0;
			err_phase_n = 1'b0;
		end
	end

	// frame due test and flash expiry
	assign elapsed   = now - last_frame_q;
	assign flash_age = now - flash_start_q;
	assign frame_due = (elapsed >= {22'd0, cfg.frame_period_ms});
	assign expired   = (flash_age > {16'd0, cfg.flash_hold_ms});
	assign is_flash  = (mode_q == lsp_pkg::MODE_CAPTURE_OK) || (mode_q == lsp_pkg::MODE_ERROR);
	assign draw_mode = (is_flash && expired) ? saved_q : mode_q;

	// breathing levels for idle and attack
	assign tri_idle  = lsp_pkg::tri_wave(now[11:4]);
	assign tri_atk   = lsp_pkg::tri_wave(now[10:3]);
	assign prod_idle = 14'(tri_idle) * 14'(lsp_pkg::IDLE_SPAN);
	assign prod_atk  = 15'(tri_atk) * 15'(lsp_pkg::ATTACK_SPAN);
	assign lvl_idle  = 8'(lsp_pkg::IDLE_BASE) + 8'(prod_idle >> lsp_pkg::LEVEL_SHIFT);
	assign lvl_atk   = 8'(lsp_pkg::ATTACK_BASE) + 8'(prod_atk >> lsp_pkg::LEVEL_SHIFT);

	// frame word towards the back
	assign push             = tick && frame_due;
	assign push_frame.mode  = draw_mode;
	assign push_frame.pos   = scan_pos_n;
	assign push_frame.level = (draw_mode == lsp_pkg::MODE_ATTACK) ? lvl_atk : lvl_idle;
	assign push_frame.on    = (draw_mode == lsp_pkg::MODE_CAPTURE_OK) ? !ok_phase_n : !err_phase_n;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			last_frame_q  <= '0;
			flash_start_q <= '0;
			mode_q        <= lsp_pkg::MODE_IDLE;
			saved_q       <= lsp_pkg::MODE_IDLE;
			scan_rem_q    <= '0;
			scan_pos_q    <= '0;
			ok_rem_q      <= '0;
			ok_phase_q    <= 1'b0;
			err_rem_q     <= '0;
			err_phase_q   <= 1'b0;
		end else if (tick) begin
			time_q      <= now;
			scan_rem_q  <= scan_rem_n;
			scan_pos_q  <= scan_pos_n;
			ok_rem_q    <= ok_rem_n;
			ok_phase_q  <= ok_phase_n;
			err_rem_q   <= err_rem_n;
			err_phase_q <= err_phase_n;
			if (frame_due) begin
				last_frame_q <= now;
				mode_q       <= draw_mode;
			end
		end else if (set_ok) begin
			if (set_flash) begin
				saved_q       <= mode_q;
				flash_start_q <= time_q;
			end
			mode_q <= lsp_pkg::mode_t'(item.mode);
		end
	end

endmodule

`default_nettype wire

FILE: src/lsp_back.sv
// Back of the pattern generator: takes frame words from the queue and sends
// one colour word per ring pixel, then the status LED. Depends on lsp_pkg.
`default_nettype none

module lsp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lsp_pkg::q_stat_t   q_stat,
	input  wire lsp_pkg::frame_t    head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output lsp_pkg::out_item_t      result
);

	lsp_pkg::frame_t           frame_q;
	logic                      active_q;
	logic [lsp_pkg::IDX_W-1:0] idx_q;
	lsp_pkg::out_item_t        result_q;
	logic                      result_valid_q;

	logic                      out_free;
	logic                      emit;
	logic                      is_status;
	logic                      frame_end;
	logic                      at_dot;
	logic [15:0]               third_prod;
	logic [7:0]                third;
	logic [7:0]                red_c;
	logic [7:0]                green_c;
	logic [7:0]                blue_c;

	// sequencing over the LEDs of one frame
	assign out_free  = !result_valid_q || !result_stall;
	assign emit      = active_q && out_free;
	assign is_status = (idx_q == lsp_pkg::IDX_W'(lsp_pkg::PIXEL_COUNT));
	assign frame_end = emit && is_status;
	assign pop       = !q_stat.empty && (!active_q || frame_end);
	assign at_dot    = (idx_q == lsp_pkg::IDX_W'(frame_q.pos));

	// one third of the breathing level for idle green
	assign third_prod = 16'(frame_q.level) * 16'(lsp_pkg::THIRD_MUL);
	assign third      = 8'(third_prod >> lsp_pkg::THIRD_SHIFT);

	// colour of the current LED
	always_comb begin
		red_c   = lsp_pkg::LVL_OFF;
		green_c = lsp_pkg::LVL_OFF;
		blue_c  = lsp_pkg::LVL_OFF;
		unique case (frame_q.mode)
			lsp_pkg::MODE_IDLE: begin
				green_c = third;
				blue_c  = frame_q.level;
			end
			lsp_pkg::MODE_SCANNING: begin
				if (is_status) begin
					blue_c = lsp_pkg::LVL_FULL;
				end else if (at_dot) begin
					blue_c = lsp_pkg::LVL_SCAN_DOT;
				end else begin
					blue_c = lsp_pkg::LVL_SCAN_DIM;
				end
			end
			lsp_pkg::MODE_ATTACK: begin
				red_c = is_status ? lsp_pkg::LVL_FULL : frame_q.level;
			end
			lsp_pkg::MODE_CAPTURE_OK: begin
				green_c = frame_q.on ? lsp_pkg::LVL_FULL : lsp_pkg::LVL_OFF;
			end
			default: begin
				red_c = frame_q.on ? lsp_pkg::LVL_FULL : lsp_pkg::LVL_OFF;
			end
		endcase
	end

	// frame register and LED counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (frame_end) begin
			active_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + lsp_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.led_index <= 4'(idx_q);
			result_q.red       <= red_c;
			result_q.green     <= green_c;
			result_q.blue      <= blue_c;
			result_q.last      <= is_status;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

FILE: src/led_status_pattern_generator.sv
// LED status pattern generator: a tick and mode-set input word, one colour
// word per LED out. Top level; depends on lsp_pkg, lsp_front, lsp_queue, lsp_back.
//
// Each input word is a one-millisecond tick or a mode set. Words are taken one
// a cycle while the two-deep frame queue has room. A tick that falls due for
// a frame (frame_period_ms since the last one) yields PIXEL_COUNT+1 result
// words, ring pixels first and the status LED last with last set; they leave
// one a cycle from the output register while result_stall is low, and each
// frame passes through the frame queue, the frame register and the output
// register. Mode sets and ticks with no frame produce no words. Configuration
// writes are always ready and take effect on the next word.
`default_nettype none

module led_status_pattern_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire lsp_pkg::in_item_t                   item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output lsp_pkg::out_item_t                       result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [15:0]                         cfg_data
);

	lsp_pkg::cfg_t    cfg_q;
	lsp_pkg::q_stat_t q_stat;
	lsp_pkg::frame_t  push_frame;
	lsp_pkg::frame_t  head;
	logic             push;
	logic             pop;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period_ms <= lsp_pkg::FRAME_PERIOD_RESET;
			cfg_q.flash_hold_ms   <= lsp_pkg::FLASH_HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsp_pkg::REG_FRAME_PERIOD: cfg_q.frame_period_ms <= cfg_data[9:0];
				lsp_pkg::REG_FLASH_HOLD:   cfg_q.flash_hold_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: time, mode and frame decisions
	lsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	// frame queue
	lsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// back: colour words
	lsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("frame pushed into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("frame popped from empty queue");

	// a frame closes on the status LED
	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (result.led_index == 4'(lsp_pkg::PIXEL_COUNT))))
		else $error("last flag does not match status LED index");

	// after a closing word is taken, the next word starts at the first pixel
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.last) ##1 result_valid
		|-> (result.led_index == 4'd0) || $stable(result))
		else $error("frame did not restart at first pixel");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for led_status_pattern_generator: drives tick and mode-set words,
// predicts every colour word of each frame and checks them in order.
// Depends on lsp_pkg and the led_status_pattern_generator RTL only.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 2000;
	localparam int BACKLOG_CYCLES = 400;
	localparam int RUN_CAP = 10;
	localparam logic [9:0] PERIOD_AFTER_RESET = 10'd33;
	localparam logic [15:0] HOLD_AFTER_RESET = 16'd600;
	localparam logic [2:0] MODE_FIELD_MAX = 3'h7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	lsp_pkg::in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	lsp_pkg::out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state and its copy of the registers
	logic [31:0] clk_ms = '0;
	logic [31:0] frame_ms = '0;
	logic [31:0] flash_ms = '0;
	lsp_pkg::mode_t shown_mode = lsp_pkg::MODE_IDLE;
	lsp_pkg::mode_t resume_mode = lsp_pkg::MODE_IDLE;
	logic [9:0] cfg_period = PERIOD_AFTER_RESET;
	logic [15:0] cfg_hold = HOLD_AFTER_RESET;

	lsp_pkg::in_item_t pending_words[$];
	lsp_pkg::out_item_t colour_words_due[$];
	int words_queued = 0;
	int words_taken = 0;
	int colours_predicted = 0;
	int colours_checked = 0;
	int frames_predicted = 0;
	int regs_written = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_gap = 0;
	int hold_left = 0;
	logic calm = 1'b0;
	logic backlog_request = 1'b0;
	logic backlog_done = 1'b0;

	led_status_pattern_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// triangle over one byte of phase
	function automatic int fold_phase(input logic [7:0] p);
		return p[7] ? 255 - int'(p) : int'(p);
	endfunction

	// advance the pattern state by one word, queue the colours it yields
	function automatic int predict_colours(input lsp_pkg::in_item_t w);
		logic [31:0] now;
		int r, g, b, sr, sg, sb, pos;
		lsp_pkg::out_item_t o;
		if (w.cmd == lsp_pkg::CMD_SET) begin
			if (w.mode > lsp_pkg::MODE_ERROR)
				return 0;
			if (w.mode == lsp_pkg::MODE_CAPTURE_OK || w.mode == lsp_pkg::MODE_ERROR) begin
				resume_mode = shown_mode;
				flash_ms = clk_ms;
			end
			shown_mode = lsp_pkg::mode_t'(w.mode);
			return 0;
		end
		clk_ms = clk_ms + 32'd1;
		now = clk_ms;
		if (now - frame_ms < {22'd0, cfg_period})
			return 0;
		frame_ms = now;
		// a flash that has outlived the hold time falls back
		if ((shown_mode == lsp_pkg::MODE_CAPTURE_OK || shown_mode == lsp_pkg::MODE_ERROR) &&
				(now - flash_ms > {16'd0, cfg_hold}))
			shown_mode = resume_mode;
		r = 0; g = 0; b = 0;
		sr = 0; sg = 0; sb = 0;
		pos = lsp_pkg::PIXEL_COUNT;
		case (shown_mode)
			lsp_pkg::MODE_IDLE: begin
				b = 10 + fold_phase(now[11:4]) * 70 / 128;
				g = b / 3;
				sg = g;
				sb = b;
			end
			lsp_pkg::MODE_SCANNING: begin
				pos = int'((now / 120) % lsp_pkg::PIXEL_COUNT);
				b = 20;
				sb = 255;
			end
			lsp_pkg::MODE_ATTACK: begin
				r = 40 + fold_phase(now[10:3]) * 215 / 128;
				sr = 255;
			end
			lsp_pkg::MODE_CAPTURE_OK: begin
				g = ((now / 80) % 2 == 0) ? 255 : 0;
				sg = g;
			end
			default: begin
				r = ((now / 150) % 2 == 0) ? 255 : 0;
				sr = r;
			end
		endcase
		for (int i = 0; i < lsp_pkg::PIXEL_COUNT; i++) begin
			o.led_index = 4'(i);
			o.red = (i == pos) ? 8'd0 : 8'(r);
			o.green = (i == pos) ? 8'd0 : 8'(g);
			o.blue = (i == pos) ? 8'd180 : 8'(b);
			o.last = 1'b0;
			colour_words_due.push_back(o);
		end
		o.led_index = 4'(lsp_pkg::PIXEL_COUNT);
		o.red = 8'(sr);
		o.green = 8'(sg);
		o.blue = 8'(sb);
		o.last = 1'b1;
		colour_words_due.push_back(o);
		frames_predicted++;
		return lsp_pkg::PIXEL_COUNT + 1;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(input logic no_gaps);
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// keep tick runs short so the whole run stays near its word budget
	function automatic int cap_run(input int n);
		return (n > RUN_CAP) ? RUN_CAP : n;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// input driver, fed from the pending word queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				words_taken++;
				colours_predicted <= colours_predicted + predict_colours(item);
			end
			if (!(item_valid && item_stall)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					item <= pending_words.pop_front();
					item_valid <= 1'b1;
					send_gap <= pick_gap(calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : colour_monitor
		lsp_pkg::out_item_t want;
		int n;
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (colours_checked >= colours_predicted) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, got %p", $time, result);
				end else begin
					want = colour_words_due.pop_front();
					compare_field("led_index", want.led_index, result.led_index);
					compare_field("red", want.red, result.red);
					compare_field("green", want.green, result.green);
					compare_field("blue", want.blue, result.blue);
					compare_field("last", want.last, result.last);
					colours_checked++;
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (backlog_request && !backlog_done) begin
				// long hold-off so the frame queue fills and the input stalls
				backlog_done <= 1'b1;
				hold_left <= BACKLOG_CYCLES;
				result_stall <= 1'b1;
			end else begin
				n = pick_gap(calm);
				result_stall <= (n > 0);
				hold_left <= (n > 0) ? n - 1 : 0;
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n && !((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_word(input logic cmd, input logic [2:0] m);
		lsp_pkg::in_item_t w;
		w.cmd = cmd;
		w.mode = m;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_word(lsp_pkg::CMD_TICK, 3'($urandom_range(0, MODE_FIELD_MAX)));
	endtask

	task automatic wait_words_taken();
		@(negedge clk);
		while (words_taken != words_queued)
			@(negedge clk);
	endtask

	// everything taken and delivered, then let the pipeline empty
	task automatic wait_idle();
		wait_words_taken();
		while (colours_checked != colours_predicted)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lsp_pkg::CFG_INDEX_W-1:0] idx, input logic [15:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == lsp_pkg::REG_FRAME_PERIOD)
			cfg_period = d[9:0];
		else
			cfg_hold = d;
		regs_written++;
	endtask

	task automatic random_op();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			push_ticks($urandom_range(1, 4));
		end else if (r < 70) begin
			push_ticks(cap_run($urandom_range(1, int'(cfg_period) + 2)));
		end else if (r < 80) begin
			// flash, sometimes stacked, then run towards the hold time
			push_word(lsp_pkg::CMD_SET,
				3'($urandom_range(lsp_pkg::MODE_CAPTURE_OK, lsp_pkg::MODE_ERROR)));
			if ($urandom_range(0, 1))
				push_word(lsp_pkg::CMD_SET,
					3'($urandom_range(lsp_pkg::MODE_CAPTURE_OK, lsp_pkg::MODE_ERROR)));
			n = int'(cfg_hold) + 2 + $urandom_range(0, int'(cfg_period));
			push_ticks(cap_run(n));
		end else if (r < 95) begin
			push_word(lsp_pkg::CMD_SET,
				3'($urandom_range(lsp_pkg::MODE_IDLE, lsp_pkg::MODE_ERROR)));
		end else begin
			push_word(lsp_pkg::CMD_SET,
				3'($urandom_range(int'(lsp_pkg::MODE_ERROR) + 1, MODE_FIELD_MAX)));
		end
	endtask

	task automatic run_random(input int min_ops, input int min_frames);
		int ops;
		int first;
		@(negedge clk);
		first = frames_predicted;
		ops = 0;
		while (ops < min_ops || frames_predicted - first < min_frames) begin
			random_op();
			ops++;
			if (ops >= min_ops)
				wait_words_taken();
		end
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// register values after reset: idle frame at 33 ms, then an error flash is set
		@(negedge clk);
		calm = 1'b1;
		push_ticks(33);
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_ERROR);
		wait_idle();

		// zero period and zero hold: a frame on every tick, flashes end at once
		write_reg(lsp_pkg::REG_FRAME_PERIOD, {6'($urandom_range(0, 63)), 10'd0});
		write_reg(lsp_pkg::REG_FLASH_HOLD, 16'd0);
		@(negedge clk);
		calm = 1'b0;
		push_ticks(1);
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_SCANNING);
		push_ticks(1);
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_ATTACK);
		push_ticks(1);
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_CAPTURE_OK);
		push_ticks(1);
		// flash over flash keeps the older flash as the fallback
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_ERROR);
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_CAPTURE_OK);
		push_ticks(2);
		push_word(lsp_pkg::CMD_SET, 3'(int'(lsp_pkg::MODE_ERROR) + 1));
		push_word(lsp_pkg::CMD_SET, 3'(int'(lsp_pkg::MODE_ERROR) + 2));
		push_word(lsp_pkg::CMD_SET, MODE_FIELD_MAX);
		push_ticks(1);
		push_word(lsp_pkg::CMD_SET, lsp_pkg::MODE_IDLE);
		push_ticks(1);
		wait_idle();

		// fastest frames, longest hold, with one long receiver hold-off
		write_reg(lsp_pkg::REG_FRAME_PERIOD, 16'd1);
		write_reg(lsp_pkg::REG_FLASH_HOLD, 16'hFFFF);
		@(negedge clk);
		backlog_request = 1'b1;
		run_random(6, 6);

		// short period and hold, no idling on either side
		write_reg(lsp_pkg::REG_FRAME_PERIOD, 16'd3);
		write_reg(lsp_pkg::REG_FLASH_HOLD, 16'd5);
		@(negedge clk);
		calm = 1'b1;
		run_random(6, 2);

		// long frames (period 1000), none fall due in this short stretch
		@(negedge clk);
		calm = 1'b0;
		write_reg(lsp_pkg::REG_FRAME_PERIOD, {6'($urandom_range(0, 63)), 10'd1000});
		write_reg(lsp_pkg::REG_FLASH_HOLD, 16'd300);
		run_random(3, 0);

		// all period bits set, hold of one
		write_reg(lsp_pkg::REG_FRAME_PERIOD, 16'hFFFF);
		write_reg(lsp_pkg::REG_FLASH_HOLD, 16'd1);
		run_random(2, 0);

		$display("Covered %0d input words across %0d register writes, %0d frames",
			words_taken, regs_written, frames_predicted);
		$display("Checked %0d colour words, %0d mismatches", colours_checked, mismatches);
		if (mismatches == 0 && colour_words_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
src/lsp_pkg.sv
src/lsp_queue.sv
src/lsp_front.sv
src/lsp_back.sv
src/led_status_pattern_generator.sv
verif/tb_top.sv
